// ===== src/ffa_pkg.sv =====
// Shared types, constants and codes of the first-fit free-list allocator.
// No dependencies; used by ffa_ctrl, ffa_dp and the top level.
`default_nettype none
package ffa_pkg;

    // heap geometry
    localparam int HEAP_UNITS  = 16384;
    localparam int UNIT_SHIFT  = 3;
    localparam int UNIT_BYTES  = 1 << UNIT_SHIFT;
    localparam int ADDR_W      = $clog2(HEAP_UNITS);
    localparam int NODE_W      = ADDR_W + 1;
    localparam int SIZE_W      = NODE_W;
    localparam int ENTRY_W     = 32;
    localparam int BYTES_W     = 17;
    localparam int CFG_W       = 15;
    localparam int MGU_RESET   = 4096;

    // walk bounds
    localparam int FREE_LIMIT  = HEAP_UNITS + 2;
    localparam int ALLOC_LIMIT = 3 * (HEAP_UNITS + 2);
    localparam int STEPF_W     = $clog2(FREE_LIMIT + 1);
    localparam int STEPA_W     = $clog2(ALLOC_LIMIT + 1);

    // input mode codes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // result status codes
    localparam logic STS_DONE = 1'b0;
    localparam logic STS_OOM  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FREE_CHK,
        ST_I_CHK,
        ST_I_RDN,
        ST_I_WRB,
        ST_I_WRP,
        ST_A_START,
        ST_A_PREV,
        ST_A_WALK,
        ST_A_SPLIT,
        ST_FIN
    } state_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_FREE_INIT,
        DP_I_STEP,
        DP_I_FOUND,
        DP_I_RDN,
        DP_I_WRB,
        DP_I_WRP,
        DP_A_START,
        DP_A_PREV,
        DP_A_ADV,
        DP_A_EXACT,
        DP_A_SPLIT,
        DP_A_SPLIT2,
        DP_A_GROW,
        DP_OOM
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   out_load;
    } cmd_t;

    typedef struct packed {
        logic free_ok;
        logic ins_found;
        logic ins_limit;
        logic fit;
        logic exact;
        logic at_rover;
        logic grow_ok;
        logic a_last;
        logic a_done;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

// ===== src/ffa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module ffa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== src/ffa_ctrl.sv =====
// Sequencing state machine of the allocator: issues datapath commands.
// Depends on ffa_pkg.
`default_nettype none
module ffa_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    input  wire logic          s_mode,
    output logic               s_ready,
    input  wire ffa_pkg::sts_t sts,
    output ffa_pkg::cmd_t      cmd
);

    ffa_pkg::state_t state_reg, state_next;
    logic            grow_ctx_reg, grow_ctx_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ffa_pkg::ST_IDLE;
            grow_ctx_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            grow_ctx_reg <= grow_ctx_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next    = state_reg;
        grow_ctx_next = grow_ctx_reg;
        cmd.op        = ffa_pkg::DP_NONE;
        cmd.out_load  = 1'b0;
        s_ready       = 1'b0;
        case (state_reg)
            ffa_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = ffa_pkg::DP_LOAD;
                    state_next = (s_mode == ffa_pkg::MODE_FREE) ? ffa_pkg::ST_FREE_CHK
                                                                : ffa_pkg::ST_A_START;
                end
            end
            ffa_pkg::ST_FREE_CHK: begin
                if (sts.free_ok) begin
                    cmd.op        = ffa_pkg::DP_FREE_INIT;
                    grow_ctx_next = 1'b0;
                    state_next    = ffa_pkg::ST_I_CHK;
                end else begin
                    state_next = ffa_pkg::ST_FIN;
                end
            end
            ffa_pkg::ST_I_CHK: begin
                if (sts.ins_found) begin
                    cmd.op     = ffa_pkg::DP_I_FOUND;
                    state_next = ffa_pkg::ST_I_RDN;
                end else if (sts.ins_limit) begin
                    state_next = grow_ctx_reg ? ffa_pkg::ST_A_START : ffa_pkg::ST_FIN;
                end else begin
                    cmd.op = ffa_pkg::DP_I_STEP;
                end
            end
            ffa_pkg::ST_I_RDN: begin
                cmd.op     = ffa_pkg::DP_I_RDN;
                state_next = ffa_pkg::ST_I_WRB;
            end
            ffa_pkg::ST_I_WRB: begin
                cmd.op     = ffa_pkg::DP_I_WRB;
                state_next = ffa_pkg::ST_I_WRP;
            end
            ffa_pkg::ST_I_WRP: begin
                cmd.op     = ffa_pkg::DP_I_WRP;
                state_next = grow_ctx_reg ? ffa_pkg::ST_A_START : ffa_pkg::ST_FIN;
            end
            ffa_pkg::ST_A_START: begin
                if (sts.a_done) begin
                    cmd.op     = ffa_pkg::DP_OOM;
                    state_next = ffa_pkg::ST_FIN;
                end else begin
                    cmd.op     = ffa_pkg::DP_A_START;
                    state_next = ffa_pkg::ST_A_PREV;
                end
            end
            ffa_pkg::ST_A_PREV: begin
                cmd.op     = ffa_pkg::DP_A_PREV;
                state_next = ffa_pkg::ST_A_WALK;
            end
            ffa_pkg::ST_A_WALK: begin
                if (sts.fit) begin
                    if (sts.exact) begin
                        cmd.op     = ffa_pkg::DP_A_EXACT;
                        state_next = ffa_pkg::ST_FIN;
                    end else begin
                        cmd.op     = ffa_pkg::DP_A_SPLIT;
                        state_next = ffa_pkg::ST_A_SPLIT;
                    end
                end else if (sts.at_rover) begin
                    if (sts.grow_ok) begin
                        cmd.op        = ffa_pkg::DP_A_GROW;
                        grow_ctx_next = 1'b1;
                        state_next    = ffa_pkg::ST_I_CHK;
                    end else begin
                        cmd.op     = ffa_pkg::DP_OOM;
                        state_next = ffa_pkg::ST_FIN;
                    end
                end else if (sts.a_last) begin
                    cmd.op     = ffa_pkg::DP_OOM;
                    state_next = ffa_pkg::ST_FIN;
                end else begin
                    cmd.op = ffa_pkg::DP_A_ADV;
                end
            end
            ffa_pkg::ST_A_SPLIT: begin
                cmd.op     = ffa_pkg::DP_A_SPLIT2;
                state_next = ffa_pkg::ST_FIN;
            end
            ffa_pkg::ST_FIN: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ffa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ffa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== src/ffa_dp.sv =====
// Datapath of the allocator: list pointers, header RAM, heap break, result word.
// Depends on ffa_pkg and ffa_ram.
`default_nettype none
module ffa_dp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire ffa_pkg::cmd_t                 cmd,
    output ffa_pkg::sts_t                      sts,
    input  wire logic [ffa_pkg::BYTES_W-1:0]   in_req,
    input  wire logic [ffa_pkg::BYTES_W-1:0]   in_rel,
    input  wire logic                          in_mode,
    input  wire logic                          cfg_we,
    input  wire logic [ffa_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic      [ffa_pkg::BYTES_W-1:0]   out_addr,
    output logic                               out_status
);

    localparam int NW = ffa_pkg::NODE_W;
    localparam int SW = ffa_pkg::SIZE_W;
    localparam int AW = ffa_pkg::ADDR_W;

    // list state
    logic [NW-1:0] rover_reg, sentinel_next_reg, heap_break_reg;
    logic          started_reg;
    logic [ffa_pkg::CFG_W-1:0] mgu_reg;
    // walk registers
    logic [NW-1:0] p_reg, prev_reg, nx_reg, bp_reg, rd_node_reg, newp_reg;
    logic [SW-1:0] nunits_reg, prev_size_reg, psz_reg, bsz_reg;
    logic [NW-1:0] bnew_next_reg;
    logic [SW-1:0] bnew_size_reg;
    logic [ffa_pkg::STEPF_W-1:0] stepf_reg;
    logic [ffa_pkg::STEPA_W-1:0] stepa_reg;
    // result and output word
    logic [ffa_pkg::BYTES_W-1:0] res_addr_reg, out_addr_reg;
    logic res_status_reg, out_status_reg, out_valid_reg;

    // RAM ports
    logic [ffa_pkg::ENTRY_W-1:0] rdata;
    logic [NW-1:0] rd_node_next, wr_node;
    logic [NW-1:0] wr_nxt;
    logic [SW-1:0] wr_size;
    logic          wr_en, ram_we;

    // header decode of the node read last cycle
    logic [NW-1:0] hdr_next;
    logic [SW-1:0] hdr_size;
    always_comb begin
        if (rd_node_reg == '0) begin
            hdr_next = sentinel_next_reg;
            hdr_size = '0;
        end else if (rd_node_reg > NW'(ffa_pkg::HEAP_UNITS)) begin
            hdr_next = '0;
            hdr_size = '0;
        end else begin
            hdr_next = rdata[SW+NW-1:SW];
            hdr_size = rdata[SW-1:0];
        end
    end

    // request arithmetic
    logic [ffa_pkg::BYTES_W:0] round_bytes;
    logic [SW-1:0] nunits_in, grow_nu, split_rem;
    logic [NW:0]   heap_room;
    logic [NW-1:0] free_bp, split_node;
    assign round_bytes = {1'b0, in_req} + (ffa_pkg::BYTES_W+1)'(ffa_pkg::UNIT_BYTES - 1);
    assign nunits_in   = SW'(round_bytes >> ffa_pkg::UNIT_SHIFT) + SW'(1);
    assign free_bp     = NW'(in_rel >> ffa_pkg::UNIT_SHIFT);
    assign grow_nu     = (nunits_reg < SW'(mgu_reg)) ? SW'(mgu_reg) : nunits_reg;
    assign heap_room   = (NW+1)'(ffa_pkg::HEAP_UNITS) - {1'b0, heap_break_reg};
    assign split_rem   = hdr_size - nunits_reg;
    assign split_node  = p_reg + NW'(split_rem);

    // merge tests
    logic merge_b, merge_p;
    logic [NW-1:0] bnew_next;
    logic [SW-1:0] bnew_size;
    assign merge_b   = ({1'b0, bp_reg} + {1'b0, bsz_reg}) == {1'b0, nx_reg};
    assign bnew_next = merge_b ? hdr_next : nx_reg;
    assign bnew_size = merge_b ? (bsz_reg + hdr_size) : bsz_reg;
    assign merge_p   = ({1'b0, p_reg} + {1'b0, psz_reg}) == {1'b0, bp_reg};

    // status to the controller
    always_comb begin
        sts.free_ok   = (bp_reg != '0) && (bp_reg <= heap_break_reg);
        sts.ins_found = ((bp_reg > p_reg) && (bp_reg < hdr_next)) ||
                        ((p_reg >= hdr_next) && ((bp_reg > p_reg) || (bp_reg < hdr_next)));
        sts.ins_limit = stepf_reg == ffa_pkg::STEPF_W'(ffa_pkg::FREE_LIMIT);
        sts.fit       = hdr_size >= nunits_reg;
        sts.exact     = hdr_size == nunits_reg;
        sts.at_rover  = p_reg == rover_reg;
        sts.grow_ok   = {1'b0, grow_nu} <= heap_room;
        sts.a_last    = stepa_reg == ffa_pkg::STEPA_W'(ffa_pkg::ALLOC_LIMIT - 1);
        sts.a_done    = stepa_reg == ffa_pkg::STEPA_W'(ffa_pkg::ALLOC_LIMIT);
        sts.out_free  = !out_valid_reg || out_ready;
    end

    // read address and write port selection
    always_comb begin
        rd_node_next = rd_node_reg;
        wr_en   = 1'b0;
        wr_node = p_reg;
        wr_nxt  = '0;
        wr_size = '0;
        case (cmd.op)
            ffa_pkg::DP_FREE_INIT: rd_node_next = rover_reg;
            ffa_pkg::DP_I_STEP:    rd_node_next = hdr_next;
            ffa_pkg::DP_I_FOUND:   rd_node_next = bp_reg;
            ffa_pkg::DP_I_RDN:     rd_node_next = nx_reg;
            ffa_pkg::DP_A_START:   rd_node_next = rover_reg;
            ffa_pkg::DP_A_PREV:    rd_node_next = hdr_next;
            ffa_pkg::DP_A_ADV:     rd_node_next = hdr_next;
            ffa_pkg::DP_I_WRB: begin
                wr_en   = 1'b1;
                wr_node = bp_reg;
                wr_nxt  = bnew_next;
                wr_size = bnew_size;
            end
            ffa_pkg::DP_I_WRP: begin
                wr_en   = 1'b1;
                wr_node = p_reg;
                wr_nxt  = merge_p ? bnew_next_reg : bp_reg;
                wr_size = merge_p ? (psz_reg + bnew_size_reg) : psz_reg;
            end
            ffa_pkg::DP_A_EXACT: begin
                wr_en   = 1'b1;
                wr_node = prev_reg;
                wr_nxt  = hdr_next;
                wr_size = prev_size_reg;
            end
            ffa_pkg::DP_A_SPLIT: begin
                // fetch the tail header so its next link survives the size write
                rd_node_next = split_node;
                wr_en   = 1'b1;
                wr_node = p_reg;
                wr_nxt  = hdr_next;
                wr_size = split_rem;
            end
            ffa_pkg::DP_A_SPLIT2: begin
                wr_en   = 1'b1;
                wr_node = newp_reg;
                wr_nxt  = hdr_next;
                wr_size = nunits_reg;
            end
            ffa_pkg::DP_A_GROW: begin
                rd_node_next = rover_reg;
                wr_en   = 1'b1;
                wr_node = heap_break_reg + NW'(1);
                wr_size = grow_nu;
            end
            default: begin
            end
        endcase
    end

    assign ram_we = wr_en && (wr_node != '0) && (wr_node <= NW'(ffa_pkg::HEAP_UNITS));

    ffa_ram #(
        .WIDTH (ffa_pkg::ENTRY_W),
        .DEPTH (ffa_pkg::HEAP_UNITS)
    ) u_hdr_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (AW'(wr_node - NW'(1))),
        .wdata ({(ffa_pkg::ENTRY_W-NW-SW)'(0), wr_nxt, wr_size}),
        .raddr (AW'(rd_node_next - NW'(1))),
        .rdata (rdata)
    );

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rover_reg         <= '0;
            sentinel_next_reg <= '0;
            heap_break_reg    <= '0;
            started_reg       <= 1'b0;
            mgu_reg           <= ffa_pkg::CFG_W'(ffa_pkg::MGU_RESET);
            out_valid_reg     <= 1'b0;
            rd_node_reg       <= '0;
        end else begin
            rd_node_reg <= rd_node_next;
            if (cfg_we) begin
                mgu_reg <= cfg_data;
            end
            // sentinel has no RAM entry
            if (wr_en && (wr_node == '0)) begin
                sentinel_next_reg <= wr_nxt;
            end
            case (cmd.op)
                ffa_pkg::DP_LOAD: begin
                    if (in_mode == ffa_pkg::MODE_ALLOC && !started_reg) begin
                        sentinel_next_reg <= '0;
                        rover_reg         <= '0;
                        started_reg       <= 1'b1;
                    end
                end
                ffa_pkg::DP_I_WRP:   rover_reg <= p_reg;
                ffa_pkg::DP_A_EXACT: rover_reg <= prev_reg;
                ffa_pkg::DP_A_SPLIT: rover_reg <= prev_reg;
                ffa_pkg::DP_A_GROW:  heap_break_reg <= heap_break_reg + NW'(grow_nu);
                default: begin
                end
            endcase
            // output word
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // walk and result registers
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_addr_reg   <= res_addr_reg;
            out_status_reg <= res_status_reg;
        end
        case (cmd.op)
            ffa_pkg::DP_LOAD: begin
                nunits_reg     <= nunits_in;
                bp_reg         <= free_bp;
                stepa_reg      <= '0;
                res_addr_reg   <= '0;
                res_status_reg <= ffa_pkg::STS_DONE;
            end
            ffa_pkg::DP_FREE_INIT: begin
                p_reg     <= rover_reg;
                stepf_reg <= '0;
            end
            ffa_pkg::DP_I_STEP: begin
                p_reg     <= hdr_next;
                stepf_reg <= stepf_reg + ffa_pkg::STEPF_W'(1);
            end
            ffa_pkg::DP_I_FOUND: begin
                nx_reg  <= hdr_next;
                psz_reg <= hdr_size;
            end
            ffa_pkg::DP_I_RDN: bsz_reg <= hdr_size;
            ffa_pkg::DP_I_WRB: begin
                bnew_next_reg <= bnew_next;
                bnew_size_reg <= bnew_size;
            end
            ffa_pkg::DP_A_START: prev_reg <= rover_reg;
            ffa_pkg::DP_A_PREV: begin
                prev_size_reg <= hdr_size;
                p_reg         <= hdr_next;
            end
            ffa_pkg::DP_A_ADV: begin
                prev_reg      <= p_reg;
                prev_size_reg <= hdr_size;
                p_reg         <= hdr_next;
                stepa_reg     <= stepa_reg + ffa_pkg::STEPA_W'(1);
            end
            ffa_pkg::DP_A_EXACT: begin
                res_addr_reg <= ffa_pkg::BYTES_W'(p_reg) << ffa_pkg::UNIT_SHIFT;
            end
            ffa_pkg::DP_A_SPLIT: newp_reg <= split_node;
            ffa_pkg::DP_A_SPLIT2: begin
                res_addr_reg <= ffa_pkg::BYTES_W'(newp_reg) << ffa_pkg::UNIT_SHIFT;
            end
            ffa_pkg::DP_A_GROW: begin
                bp_reg    <= heap_break_reg + NW'(1);
                p_reg     <= rover_reg;
                stepf_reg <= '0;
                stepa_reg <= stepa_reg + ffa_pkg::STEPA_W'(1);
            end
            ffa_pkg::DP_OOM: res_status_reg <= ffa_pkg::STS_OOM;
            default: begin
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign out_addr   = out_addr_reg;
    assign out_status = out_status_reg;

endmodule
`default_nettype wire

// ===== src/first_fit_free_list_allocator.sv =====
// Top level of the first-fit free-list heap allocator.
// Depends on ffa_pkg, ffa_ctrl and ffa_dp (which holds ffa_ram).
`default_nettype none
// Heap allocator over 16384 units of 8 bytes with an address-ordered circular
// free list held in a 16384 x 32 header RAM. Each input word either allocates
// (tuser = 0) or frees (tuser = 1) and yields exactly one result word. One word
// is processed at a time; the free-list walk makes one header RAM read per
// cycle. An allocate walks the list for a fitting block, splits it when it is
// larger than asked, and grows the heap when the walk is back at the rover,
// inserting the new block by a walk; a free walks to its place in the list,
// and one outside the heap yields its result without a walk. The next word
// can be accepted in the cycle after the result is loaded, and may be taken
// while that result still waits on the output register. The header RAM needs
// no clearing after reset. min_grow_units may be written only while idle.
module first_fit_free_list_allocator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input words
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // request_bytes[16:0], release_addr[33:17], zero pad
    input  wire logic [0:0]  s_tuser,   // mode
    // result words
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,   // payload_addr[16:0], zero pad
    output logic      [0:0]  m_tuser,   // status
    // min_grow_units write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [14:0] cfg_data
);

    ffa_pkg::cmd_t cmd;
    ffa_pkg::sts_t sts;
    logic [ffa_pkg::BYTES_W-1:0] out_addr;
    logic out_status;

    assign cfg_ready = 1'b1;

    ffa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_mode  (s_tuser[0]),
        .s_ready (s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ffa_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_req     (s_tdata[16:0]),
        .in_rel     (s_tdata[33:17]),
        .in_mode    (s_tuser[0]),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_addr   (out_addr),
        .out_status (out_status)
    );

    assign m_tdata = {7'b0, out_addr};
    assign m_tuser = out_status;

`ifndef SYNTH
    // one word in flight: accepting a word drops ready
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input word accepted while another is in flight");

    // out of memory carries a null payload
    a_oom_null: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] == ffa_pkg::STS_OOM) |-> m_tdata[16:0] == 17'd0)
        else $error("out-of-memory result with non-zero payload");

    // a new result is only loaded at the end of a word's processing
    a_result_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result loaded while idle");
`endif

endmodule
`default_nettype wire
